/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define DSW_ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DSW_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/dsw_pkg.sv */
package dsw_pkg;

   localparam int REG_WIDTH = 16;

   localparam logic [1:0] CSR_SENSOR_TYPE   = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd1;
   localparam logic [1:0] CSR_WAKE_TICKS    = 2'd2;

   localparam logic RESET_SENSOR_TYPE = 1'b1;
   localparam logic [REG_WIDTH-1:0] RESET_TIMEOUT_TICKS = 16'd2400;
   localparam logic [REG_WIDTH-1:0] RESET_WAKE_TICKS    = 16'd18000;

   localparam logic SENSOR_DHT11 = 1'b0;
   localparam logic SENSOR_DHT22 = 1'b1;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_CHECKSUM = 3'd1;
   localparam logic [2:0] STATUS_DATA_TO  = 3'd2;
   localparam logic [2:0] STATUS_CONNECT  = 3'd3;
   localparam logic [2:0] STATUS_ACK_LOW  = 3'd4;
   localparam logic [2:0] STATUS_ACK_HIGH = 3'd5;

   localparam int FRAME_WIDTH = 40;
   localparam logic [5:0] FRAME_BITS = 6'd40;
   localparam logic [5:0] LEAD_DHT11 = 6'd1;
   localparam logic [5:0] LEAD_DHT22 = 6'd6;

   typedef struct packed {
      logic kind;
      logic pin_level;
   } req_type;

   typedef struct packed {
      logic               drive_low;
      logic               done_res;
      logic [2:0]         status;
      logic [10:0]        humidity_tenths;
      logic signed [11:0] temperature_tenths;
   } rsp_type;

   typedef struct packed {
      logic                 sensor_type;
      logic [REG_WIDTH-1:0] timeout_ticks;
      logic [REG_WIDTH-1:0] wake_ticks;
   } cfg_type;

   typedef struct packed {
      logic               bad_sum;
      logic [10:0]        humidity;
      logic signed [11:0] temperature;
   } decode_type;

endpackage

/* design/dsw_frame_decode.sv */
module dsw_frame_decode
   import dsw_pkg::*;
(
   input  logic [FRAME_WIDTH-1:0] frame,
   input  logic                   sensor_type,
   output decode_type             decoded
);

   logic [7:0]  b0, b1, b2, b3, b4;
   logic [7:0]  m0, m2;
   logic [7:0]  sum;
   logic [11:0] magnitude;

   assign b0 = frame[39:32];
   assign b1 = frame[31:24];
   assign b2 = frame[23:16];
   assign b3 = frame[15:8];
   assign b4 = frame[7:0];

   always_comb begin
      magnitude = '0;
      if (sensor_type == SENSOR_DHT11) begin
         m0 = b0 & 8'h7F;
         m2 = b2 & 8'h7F;
         decoded.humidity    = 11'(m0) * 11'd10;
         decoded.temperature = $signed(12'(m2) * 12'd10);
      end else begin
         m0 = b0 & 8'h03;
         m2 = b2 & 8'h83;
         decoded.humidity = {1'b0, m0[1:0], b1};
         magnitude        = {2'b00, m2[1:0], b3};
         decoded.temperature = m2[7] ? $signed(-magnitude) : $signed(magnitude);
      end
      sum = m0 + b1 + m2 + b3;
      decoded.bad_sum = (sum != b4);
   end

endmodule

/* design/dsw_line_fsm.sv */
`include "assert_macros.svh"

module dsw_line_fsm
   import dsw_pkg::*;
#(
   parameter int TICK_WIDTH = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type rsp
);

   localparam int WIDE = (TICK_WIDTH > REG_WIDTH ? TICK_WIDTH : REG_WIDTH) + 1;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_WAKE = 3'd1;
   localparam logic [2:0] PH_CONN = 3'd2;
   localparam logic [2:0] PH_ACKL = 3'd3;
   localparam logic [2:0] PH_ACKH = 3'd4;
   localparam logic [2:0] PH_DATA = 3'd5;

   function automatic logic [TICK_WIDTH-1:0] clamp_ticks(input logic [REG_WIDTH-1:0] value);
      logic [WIDE-1:0] wide_value;
      wide_value = WIDE'(value);
      if (value == '0) begin
         return TICK_WIDTH'(1);
      end else if (wide_value > WIDE'({TICK_WIDTH{1'b1}})) begin
         return '1;
      end else begin
         return wide_value[TICK_WIDTH-1:0];
      end
   endfunction

   logic [2:0]             phase_ff, phase_in;
   logic [TICK_WIDTH-1:0]  tick_ff, tick_in;
   logic                   prev_ff, prev_in;
   logic [5:0]             bits_ff, bits_in;
   logic [FRAME_WIDTH-1:0] frame_ff, frame_in;
   logic [TICK_WIDTH-1:0]  zref_ff, zref_in;
   logic [TICK_WIDTH-1:0]  margin_ff, margin_in;

   logic [TICK_WIDTH-1:0]  limit;
   logic [TICK_WIDTH-1:0]  wake_left;
   logic [TICK_WIDTH:0]    limit_x2;
   logic [TICK_WIDTH-1:0]  conn_limit;
   logic [5:0]             lead;
   logic                   one_bit;

   logic                   drive;
   logic                   done;
   logic [2:0]             status;
   logic                   frame_done;
   decode_type             decoded;

   assign limit      = clamp_ticks(cfg.timeout_ticks);
   assign wake_left  = clamp_ticks(cfg.wake_ticks) - TICK_WIDTH'(1);
   assign limit_x2   = {limit, 1'b0};
   assign conn_limit = limit_x2[TICK_WIDTH] ? '1 : limit_x2[TICK_WIDTH-1:0];
   assign lead       = (cfg.sensor_type == SENSOR_DHT11) ? LEAD_DHT11 : LEAD_DHT22;
   assign one_bit    = $signed({2'b00, tick_ff})
                       <= ($signed({2'b00, zref_ff}) - $signed({2'b00, margin_ff}));

   always_comb begin
      logic [TICK_WIDTH-1:0] cnt;
      logic [TICK_WIDTH-1:0] zref_v;
      logic                  bit_v;
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      prev_in    = prev_ff;
      bits_in    = bits_ff;
      frame_in   = frame_ff;
      zref_in    = zref_ff;
      margin_in  = margin_ff;
      drive      = 1'b0;
      done       = 1'b0;
      status     = STATUS_OK;
      frame_done = 1'b0;
      cnt        = tick_ff;
      zref_v     = zref_ff;
      bit_v      = 1'b0;
      if (item.kind) begin
         if (phase_ff != PH_IDLE) begin
            drive = (phase_ff == PH_WAKE);
         end else begin
            bits_in   = FRAME_BITS;
            frame_in  = '0;
            zref_in   = limit;
            margin_in = '0;
            prev_in   = 1'b0;
            drive     = 1'b1;
            if (wake_left == '0) begin
               phase_in = PH_CONN;
               tick_in  = conn_limit;
            end else begin
               phase_in = PH_WAKE;
               tick_in  = wake_left;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
            PH_WAKE: begin
               drive = 1'b1;
               if (cnt != '0) cnt = cnt - TICK_WIDTH'(1);
               if (cnt == '0) begin
                  phase_in = PH_CONN;
                  tick_in  = conn_limit;
               end else begin
                  tick_in = cnt;
               end
            end
            PH_CONN, PH_ACKL, PH_ACKH: begin
               if (item.pin_level == (phase_ff != PH_ACKL)) begin
                  if (cnt != '0) cnt = cnt - TICK_WIDTH'(1);
                  tick_in = cnt;
                  if (cnt == '0) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                     if (phase_ff == PH_CONN) begin
                        status = STATUS_CONNECT;
                     end else if (phase_ff == PH_ACKL) begin
                        status = STATUS_ACK_LOW;
                     end else begin
                        status = STATUS_ACK_HIGH;
                     end
                  end
               end else begin
                  if (phase_ff == PH_ACKH) prev_in = 1'b0;
                  phase_in = phase_ff + 3'd1;
                  tick_in  = limit;
               end
            end
            PH_DATA: begin
               if (!item.pin_level && prev_ff && bits_ff != '0) begin
                  if (bits_ff > FRAME_BITS - lead) begin
                     if (zref_v > tick_ff) zref_v = tick_ff;
                     zref_in   = zref_v;
                     margin_in = (limit > zref_v) ? ((limit - zref_v) >> 2) : '0;
                  end else begin
                     bit_v = one_bit;
                  end
                  frame_in = {frame_ff[FRAME_WIDTH-2:0], bit_v};
                  bits_in  = bits_ff - 6'd1;
                  cnt      = limit;
               end
               prev_in = item.pin_level;
               if (cnt != '0) cnt = cnt - TICK_WIDTH'(1);
               tick_in = cnt;
               if (cnt == '0) begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
                  status   = STATUS_DATA_TO;
               end else if (bits_in == '0) begin
                  phase_in   = PH_IDLE;
                  done       = 1'b1;
                  frame_done = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   dsw_frame_decode u_decode (
      .frame       (frame_in),
      .sensor_type (cfg.sensor_type),
      .decoded     (decoded)
   );

   always_comb begin
      rsp.drive_low          = drive;
      rsp.done_res           = done;
      rsp.status             = status;
      rsp.humidity_tenths    = '0;
      rsp.temperature_tenths = '0;
      if (frame_done) begin
         rsp.status             = decoded.bad_sum ? STATUS_CHECKSUM : STATUS_OK;
         rsp.humidity_tenths    = decoded.humidity;
         rsp.temperature_tenths = decoded.temperature;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         tick_ff   <= '0;
         prev_ff   <= 1'b0;
         bits_ff   <= FRAME_BITS;
         frame_ff  <= '0;
         zref_ff   <= '0;
         margin_ff <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         prev_ff   <= prev_in;
         bits_ff   <= bits_in;
         frame_ff  <= frame_in;
         zref_ff   <= zref_in;
         margin_ff <= margin_in;
      end
   end

   `DSW_ASSERT_ALWAYS(a_done_not_driving, clock, rsp.done_res |-> !rsp.drive_low, "drive low on a finish")
   `DSW_ASSERT_SYNC(a_bits_in_range, clock, reset, bits_ff <= FRAME_BITS, "bit count out of range")
   `DSW_ASSERT_SYNC(a_wire_error_zero, clock, reset, (step && rsp.status >= STATUS_DATA_TO) |-> (rsp.humidity_tenths == '0 && rsp.temperature_tenths == '0), "wire error with data")
   `DSW_ASSERT_SYNC(a_status_needs_done, clock, reset, (step && rsp.status != STATUS_OK) |-> rsp.done_res, "status without finish")

endmodule

/* design/dht_single_wire_reader.sv */
// Single-wire humidity/temperature sensor reader for DHT11 and DHT22/DHT21 framing.
// Each req_ transfer is one sample of the data line or a start request, and each
// produces exactly one rsp_ transfer: drive_low tells the pad to pull the line low
// during wake-up, and done_res marks the sample on which a read ends with status,
// humidity and temperature in tenths. One sample is taken every cycle while the
// response side does not stall; a sample passes the input register, then the
// combinational line-protocol update and frame decode, into the result register.
// Registers are written through the csr_ port; the user must write them only while
// no read is in flight, as the block does not enforce it. Index 0 sensor type,
// 1 per-level timeout in ticks, 2 wake-up length in ticks.
`include "assert_macros.svh"

module dht_single_wire_reader
   import dsw_pkg::*;
#(
   parameter int TICK_WIDTH = 16
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_write_en,
   input  logic [1:0]           csr_index,
   input  logic [REG_WIDTH-1:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    advance;
   rsp_type result;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_type   <= RESET_SENSOR_TYPE;
         cfg_ff.timeout_ticks <= RESET_TIMEOUT_TICKS;
         cfg_ff.wake_ticks    <= RESET_WAKE_TICKS;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SENSOR_TYPE:   cfg_ff.sensor_type   <= csr_wdata[0];
            CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_wdata;
            CSR_WAKE_TICKS:    cfg_ff.wake_ticks    <= csr_wdata;
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   dsw_line_fsm #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_fsm (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_data_ff),
      .cfg   (cfg_ff),
      .rsp   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result;
      end
   end

   `DSW_ASSERT_SYNC(a_stall_only_on_full, clock, reset, (in_valid_ff && !req_ready) |-> (out_valid_ff && !rsp_ready), "input held without output stall")

endmodule

/* dv/dht_single_wire_reader_tb.sv */
`timescale 1ns / 1ps

module dht_single_wire_reader_tb;
   import dsw_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int TICK_MAX = 65535;
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_START = 1'b1;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [2:0] {
      LINK_IDLE, LINK_WAKE, LINK_CONNECT, LINK_ACK_LOW, LINK_ACK_HIGH, LINK_DATA
   } link_phase_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [REG_WIDTH-1:0] csr_wdata = '0;

   req_type pending[$];
   rsp_type expected[$];
   rsp_type want;
   logic req_fired = 1'b0;
   int failures = 0;
   int cycle_count = 0;
   int send_gap_pct = 0;
   int stall_pct = 0;
   int interject_pct = 0;

   logic cfg_sensor = RESET_SENSOR_TYPE;
   logic [15:0] cfg_timeout = RESET_TIMEOUT_TICKS;
   logic [15:0] cfg_wake = RESET_WAKE_TICKS;

   link_phase_type link_phase = LINK_IDLE;
   int line_count = 0;
   logic last_level = 1'b0;
   int bits_remaining = FRAME_WIDTH;
   logic [39:0] captured_bits = '0;
   int zero_ref = 0;
   int margin_ticks = 0;

   dht_single_wire_reader dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   function automatic int ticks_or_one(logic [15:0] v);
      return (v == 0) ? 1 : int'(v);
   endfunction

   function automatic int connect_limit(int t);
      return (2 * t > TICK_MAX) ? TICK_MAX : 2 * t;
   endfunction

   function automatic rsp_type decode_frame();
      rsp_type r;
      logic [7:0] b0, b1, b2, b3, b4, sum;
      int hum;
      int temp;
      {b0, b1, b2, b3, b4} = captured_bits;
      if (cfg_sensor == SENSOR_DHT11) begin
         b0 = b0 & 8'h7F;
         b2 = b2 & 8'h7F;
         hum = b0 * 10;
         temp = b2 * 10;
      end else begin
         b0 = b0 & 8'h03;
         b2 = b2 & 8'h83;
         hum = b0 * 256 + b1;
         temp = b2[6:0] * 256 + b3;
         if (b2[7]) temp = -temp;
      end
      sum = b0 + b1 + b2 + b3;
      r = '0;
      r.done_res = 1'b1;
      r.status = (sum != b4) ? STATUS_CHECKSUM : STATUS_OK;
      r.humidity_tenths = hum[10:0];
      r.temperature_tenths = temp[11:0];
      return r;
   endfunction

   function automatic rsp_type sense_line(req_type item);
      rsp_type r;
      int t;
      int lead;
      logic waits;
      logic bit_val;
      r = '0;
      t = ticks_or_one(cfg_timeout);
      if (item.kind == REQ_START) begin
         if (link_phase != LINK_IDLE) begin
            r.drive_low = (link_phase == LINK_WAKE);
            return r;
         end
         bits_remaining = FRAME_WIDTH;
         captured_bits = '0;
         zero_ref = t;
         margin_ticks = 0;
         last_level = 1'b0;
         line_count = ticks_or_one(cfg_wake) - 1;
         if (line_count == 0) begin
            link_phase = LINK_CONNECT;
            line_count = connect_limit(t);
         end else begin
            link_phase = LINK_WAKE;
         end
         r.drive_low = 1'b1;
         return r;
      end
      case (link_phase)
         LINK_WAKE: begin
            if (line_count > 0) line_count--;
            if (line_count == 0) begin
               link_phase = LINK_CONNECT;
               line_count = connect_limit(t);
            end
            r.drive_low = 1'b1;
         end
         LINK_CONNECT, LINK_ACK_LOW, LINK_ACK_HIGH: begin
            waits = (link_phase != LINK_ACK_LOW);
            if (item.pin_level == waits) begin
               if (line_count > 0) line_count--;
               if (line_count == 0) begin
                  r.done_res = 1'b1;
                  r.status = (link_phase == LINK_CONNECT) ? STATUS_CONNECT :
                             (link_phase == LINK_ACK_LOW) ? STATUS_ACK_LOW : STATUS_ACK_HIGH;
                  link_phase = LINK_IDLE;
               end
            end else begin
               if (link_phase == LINK_ACK_HIGH) last_level = 1'b0;
               link_phase = (link_phase == LINK_CONNECT) ? LINK_ACK_LOW :
                            (link_phase == LINK_ACK_LOW) ? LINK_ACK_HIGH : LINK_DATA;
               line_count = t;
            end
         end
         LINK_DATA: begin
            if (!item.pin_level && last_level && bits_remaining > 0) begin
               lead = (cfg_sensor == SENSOR_DHT11) ? LEAD_DHT11 : LEAD_DHT22;
               bit_val = 1'b0;
               if (bits_remaining > FRAME_WIDTH - lead) begin
                  if (zero_ref > line_count) zero_ref = line_count;
                  margin_ticks = (t > zero_ref) ? (t - zero_ref) / 4 : 0;
               end else if (line_count <= zero_ref - margin_ticks) begin
                  bit_val = 1'b1;
               end
               captured_bits = {captured_bits[38:0], bit_val};
               bits_remaining--;
               line_count = t;
            end
            last_level = item.pin_level;
            if (line_count > 0) line_count--;
            if (line_count == 0) begin
               r.done_res = 1'b1;
               r.status = STATUS_DATA_TO;
               link_phase = LINK_IDLE;
            end else if (bits_remaining == 0) begin
               r = decode_frame();
               link_phase = LINK_IDLE;
            end
         end
         default: link_phase = LINK_IDLE;
      endcase
      return r;
   endfunction

   function automatic logic [39:0] sealed_frame(logic [31:0] body, logic sensor);
      logic [7:0] m0, m2, sum;
      m0 = (sensor == SENSOR_DHT11) ? (body[31:24] & 8'h7F) : (body[31:24] & 8'h03);
      m2 = (sensor == SENSOR_DHT11) ? (body[15:8] & 8'h7F) : (body[15:8] & 8'h83);
      sum = m0 + body[23:16] + m2 + body[7:0];
      return {body, sum};
   endfunction

   task automatic push_item(input logic kind, input logic level);
      req_type r;
      r.kind = kind;
      r.pin_level = level;
      pending.push_back(r);
   endtask

   task automatic queue_run(input logic level, input int count, input bit interject);
      repeat (count) begin
         if (interject && $urandom_range(99) < interject_pct)
            push_item(REQ_START, 1'($urandom_range(1)));
         push_item(REQ_SAMPLE, level);
      end
   endtask

   // break_at: -1 clean, 0 connect, 1 ack low, 2 ack high, 3..42 data bit
   task automatic queue_read(input logic [39:0] frame, input int break_at);
      int t;
      int w;
      t = ticks_or_one(cfg_timeout);
      w = ticks_or_one(cfg_wake);
      push_item(REQ_START, 1'($urandom_range(1)));
      repeat (w - 1) queue_run(1'($urandom_range(1)), 1, 1);
      if (break_at == 0) begin
         queue_run(1'b1, connect_limit(t) + $urandom_range(2), 0);
         return;
      end
      queue_run(1'b1, $urandom_range(0, (2 * t - 1 < 4) ? 2 * t - 1 : 4), 1);
      if (break_at == 1) begin
         queue_run(1'b0, t + 1 + $urandom_range(2), 0);
         return;
      end
      queue_run(1'b0, $urandom_range(1, (t < 3) ? t : 3), 1);
      if (break_at == 2) begin
         queue_run(1'b1, t + 1 + $urandom_range(2), 0);
         return;
      end
      queue_run(1'b1, $urandom_range(1, (t < 3) ? t : 3), 1);
      queue_run(1'b0, $urandom_range(1, 2), 1);
      for (int i = 39; i >= 0; i--) begin
         if (break_at == 42 - i) begin
            queue_run(1'b1, t + $urandom_range(2), 0);
            return;
         end
         queue_run(1'b1, frame[i] ? $urandom_range(5, 8) : $urandom_range(1, 2), 1);
         queue_run(1'b0, (i == 0) ? 1 : $urandom_range(1, 2), i != 0);
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_SENSOR_TYPE: cfg_sensor = val[0];
         CSR_TIMEOUT_TICKS: cfg_timeout = val;
         CSR_WAKE_TICKS: cfg_wake = val;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // drain, then push high samples until any unfinished read ends
   task automatic settle();
      forever begin
         while (pending.size() != 0 || req_valid || expected.size() != 0)
            @(posedge clock);
         if (link_phase == LINK_IDLE) break;
         push_item(REQ_SAMPLE, 1'b1);
      end
      repeat (4) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_data <= pending.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      req_fired <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) expected.push_back(sense_line(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected.size() == 0) begin
               $error("rsp transfer with no expected result");
               failures++;
            end else begin
               want = expected.pop_front();
               if (rsp_data.drive_low !== want.drive_low) begin
                  $error("drive_low: expected %0d, got %0d", want.drive_low, rsp_data.drive_low);
                  failures++;
               end
               if (rsp_data.done_res !== want.done_res) begin
                  $error("done_res: expected %0d, got %0d", want.done_res, rsp_data.done_res);
                  failures++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  failures++;
               end
               if (rsp_data.humidity_tenths !== want.humidity_tenths) begin
                  $error("humidity_tenths: expected %0d, got %0d",
                         want.humidity_tenths, rsp_data.humidity_tenths);
                  failures++;
               end
               if (rsp_data.temperature_tenths !== want.temperature_tenths) begin
                  $error("temperature_tenths: expected %0d, got %0d",
                         want.temperature_tenths, rsp_data.temperature_tenths);
                  failures++;
               end
            end
         end
      end
   end

   initial begin
      logic [31:0] body;
      logic [39:0] frame;
      logic [7:0] flip;
      int roll;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_item(REQ_SAMPLE, 1'b0);
      push_item(REQ_SAMPLE, 1'b1);
      settle();
      write_reg(CSR_WAKE_TICKS, 16'd0);
      write_reg(CSR_TIMEOUT_TICKS, 16'd1);
      queue_read('0, 0);
      queue_read('0, 1);
      settle();
      write_reg(CSR_TIMEOUT_TICKS, 16'd0);
      write_reg(CSR_WAKE_TICKS, 16'd1);
      queue_read('0, 2);
      queue_read('0, 3);
      push_item(REQ_START, 1'b0);
      push_item(REQ_START, 1'b1);
      queue_run(1'b1, 2, 0);
      settle();

      write_reg(CSR_WAKE_TICKS, 16'd4);
      write_reg(CSR_TIMEOUT_TICKS, 16'hFFFF);
      interject_pct = 1;
      queue_read(sealed_frame(32'h0164_8065, SENSOR_DHT22), -1);
      settle();
      interject_pct = 0;

      write_reg(CSR_UNUSED, 16'h0005);
      write_reg(CSR_SENSOR_TYPE, 16'(SENSOR_DHT11));
      write_reg(CSR_TIMEOUT_TICKS, 16'd20);
      write_reg(CSR_WAKE_TICKS, 16'd3);
      queue_read(sealed_frame(32'h7F00_7F00, SENSOR_DHT11) ^ 40'h1, -1);

      for (int mode = 0; mode < 4; mode++) begin
         settle();
         write_reg(CSR_SENSOR_TYPE,
                   (mode == 0 || mode == 3) ? 16'(SENSOR_DHT11) : 16'(SENSOR_DHT22));
         write_reg(CSR_TIMEOUT_TICKS, 16'($urandom_range(16, 48)));
         write_reg(CSR_WAKE_TICKS, 16'($urandom_range(1, 12)));
         send_gap_pct = (mode == 1) ? 69 : (mode == 3) ? 20 : 0;
         stall_pct = (mode == 2) ? 69 : (mode == 3) ? 20 : 0;
         interject_pct = 3;
         repeat ((mode == 1 || mode == 2) ? 2 : 1) begin
            repeat ($urandom_range(0, 3)) push_item(REQ_SAMPLE, 1'($urandom_range(1)));
            body = $urandom;
            if ($urandom_range(9) != 0) begin
               if (cfg_sensor == SENSOR_DHT11) body[31] = 1'b0;
               else body[31:26] = '0;
            end
            frame = sealed_frame(body, cfg_sensor);
            if ($urandom_range(4) == 0) begin
               flip = 8'($urandom_range(1, 255));
               frame[7:0] = frame[7:0] ^ flip;
            end
            roll = int'($urandom_range(99));
            queue_read(frame, (roll < 40) ? -1 : int'($urandom_range(0, 42)));
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (failures == 0 && expected.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
